// File: design/elevator_dispatch_controller_macros.svh
// Assertion macros for the elevator dispatch controller.
// Included by files that check their own logic; needs clk and rst_n in scope.
`ifndef ELEVATOR_DISPATCH_CONTROLLER_MACROS_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define EDC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EDC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/edc_pkg.sv
// Shared types and constants of the elevator dispatch controller.
// No dependencies; imported by edc_front, edc_back and the top level.
`timescale 1ns / 1ps

package edc_pkg;

  localparam int FLW = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CFG_MAX_LOAD     = 2'd0;
  localparam logic [1:0] CFG_RIDER_WEIGHT = 2'd1;
  localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd2;

  localparam logic [9:0] MAX_LOAD_RST     = 10'd600;
  localparam logic [7:0] RIDER_WEIGHT_RST = 8'd70;
  localparam logic [7:0] IDLE_LIMIT_RST   = 8'd25;

  typedef struct packed {
    logic           op;
    logic [FLW-1:0] from_floor;
    logic [FLW-1:0] to_floor;
  } in_item_t;

  typedef struct packed {
    logic [FLW-1:0] car_floor;
    logic           going_up;
    logic           moved;
    logic [4:0]     rider_count;
    logic [11:0]    load_weight;
    logic [1:0]     request_status;
  } out_item_t;

  typedef struct packed {
    logic           op;
    logic [FLW-1:0] from_floor;
    logic           bad;
  } work_t;

  typedef struct packed {
    logic [9:0] max_load;
    logic [7:0] rider_weight;
    logic [7:0] idle_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_PASS,
    S_MOVE,
    S_DONE
  } back_state_t;

endpackage

// File: design/edc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module edc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: design/edc_front.sv
// Front end: two-entry transaction queue that checks floor numbers on entry.
// Depends on edc_pkg.
`timescale 1ns / 1ps

module edc_front
  import edc_pkg::*;
#(
  parameter int NUM_FLOORS = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_data,
  output logic     wk_valid,
  output work_t    wk,
  input  logic     wk_pop
);

  work_t      q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, bad;

  assign in_full  = (cnt_r == 2'd2);
  assign push     = in_push && !in_full;
  assign wk_valid = (cnt_r != 2'd0);
  assign pop      = wk_pop && wk_valid;
  assign wk       = q_r[rp_r];

  assign bad = ({1'b0, in_data.from_floor} >= 4'(NUM_FLOORS))
            || ({1'b0, in_data.to_floor} >= 4'(NUM_FLOORS))
            || (in_data.from_floor == in_data.to_floor);

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= '{op: in_data.op, from_floor: in_data.from_floor, bad: bad};
    end
  end

endmodule

// File: design/edc_back.sv
// Back end: sequencer that carries out add and tick transactions.
// Depends on edc_pkg and edc_ram (waiting destinations per floor).
`timescale 1ns / 1ps

module edc_back
  import edc_pkg::*;
#(
  parameter int NUM_FLOORS  = 6,
  parameter int QUEUE_DEPTH = 8,
  parameter int CAB_LIMIT   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      wk_valid,
  input  work_t     wk,
  input  logic [FLW-1:0] wk_to,
  output logic      wk_pop,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  localparam int QIW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW       = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = 8 << QIW;
  localparam int RAW       = FLW + QIW;

  back_state_t    state_r, state_nxt;
  logic [FLW-1:0] pos_r;
  logic           up_r;
  logic [7:0]     idle_r;
  logic [4:0]     n_r;
  logic [4:0]     rid_r [8];
  logic [QCW-1:0] cnt_r [8];
  logic [QCW-1:0] idx_r, keep_r;
  logic           took_r, pass_r, moved_r;
  logic [1:0]     stat_r;

  logic [FLW-1:0] fsel, rsel, d;
  logic [QCW-1:0] cnt_sel;
  logic [4:0]     rid_sel;
  logic [7:0]     rnz, wnz, gt_mask, lt_mask;
  logic           any_wait, above, below, want_up, want_dn, head_ok, may;
  logic [12:0]    prod, load;
  logic [7:0]     idle_inc;
  logic           ram_we;
  logic [RAW-1:0] ram_waddr, ram_raddr;
  logic [FLW-1:0] ram_wdata, ram_rdata;

  edc_ram #(.WIDTH(FLW), .DEPTH(RAM_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    d        = ram_rdata;
    fsel     = (state_r == S_IDLE) ? wk.from_floor : pos_r;
    rsel     = (state_r == S_IDLE) ? pos_r : d;
    cnt_sel  = cnt_r[fsel];
    rid_sel  = rid_r[rsel];
    for (int i = 0; i < 8; i++) begin
      rnz[i]     = (rid_r[i] != 5'd0);
      wnz[i]     = (cnt_r[i] != '0);
      gt_mask[i] = (3'(i) > pos_r);
      lt_mask[i] = (3'(i) < pos_r);
    end
    any_wait = |wnz;
    above    = |(wnz & gt_mask);
    below    = |(wnz & lt_mask);
    want_up  = |(rnz & gt_mask);
    want_dn  = |(rnz & lt_mask);
    head_ok  = up_r ? (d > pos_r) : (d < pos_r);
    prod     = ({8'd0, n_r} + 13'd1) * {5'd0, cfg.rider_weight};
    may      = (n_r < 5'(CAB_LIMIT)) && (prod <= {3'd0, cfg.max_load});
    load     = {8'd0, n_r} * {5'd0, cfg.rider_weight};
    idle_inc = (idle_r == 8'hFF) ? idle_r : idle_r + 8'd1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (wk_valid) begin
          if (wk.op == OP_TICK && (n_r != 5'd0 || any_wait)) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD:   state_nxt = (idx_r == cnt_sel) ? S_PASS : S_EVAL;
      S_EVAL: state_nxt = S_RD;
      S_PASS: begin
        if (!pass_r && !took_r && keep_r != '0) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: state_nxt = S_DONE;
      S_DONE: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    wk_pop    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {pos_r, keep_r[QIW-1:0]};
    ram_wdata = d;
    ram_raddr = {pos_r, idx_r[QIW-1:0]};
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        wk_pop = wk_valid;
        if (wk_valid && wk.op == OP_ADD && !wk.bad && cnt_sel < QCW'(QUEUE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = {wk.from_floor, cnt_sel[QIW-1:0]};
          ram_wdata = wk_to;
        end
      end
      S_EVAL:  ram_we = !(may && head_ok);
      S_DONE:  res_valid = 1'b1;
      default: ;
    endcase
    res = '{car_floor: pos_r, going_up: up_r, moved: moved_r, rider_count: n_r,
            load_weight: load[11:0], request_status: stat_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      up_r    <= 1'b1;
      idle_r  <= 8'd0;
      n_r     <= 5'd0;
      for (int i = 0; i < 8; i++) begin
        rid_r[i] <= 5'd0;
        cnt_r[i] <= '0;
      end
      idx_r   <= '0;
      keep_r  <= '0;
      took_r  <= 1'b0;
      pass_r  <= 1'b0;
      moved_r <= 1'b0;
      stat_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (wk_valid) begin
            moved_r <= 1'b0;
            stat_r  <= ST_OK;
            if (wk.op == OP_ADD) begin
              if (wk.bad) begin
                stat_r <= ST_BAD;
              end else if (cnt_sel >= QCW'(QUEUE_DEPTH)) begin
                stat_r <= ST_FULL;
              end else begin
                cnt_r[wk.from_floor] <= cnt_sel + QCW'(1);
              end
            end else if (n_r == 5'd0 && !any_wait) begin
              idle_r <= idle_inc;
              if (idle_inc > cfg.idle_limit && pos_r != '0) begin
                pos_r   <= pos_r - 3'd1;
                moved_r <= 1'b1;
              end
            end else begin
              idle_r      <= 8'd0;
              n_r         <= n_r - rid_sel;
              rid_r[pos_r] <= 5'd0;
              idx_r       <= '0;
              keep_r      <= '0;
              took_r      <= 1'b0;
              pass_r      <= 1'b0;
            end
          end
        end
        S_EVAL: begin
          if (may && head_ok) begin
            rid_r[d] <= rid_sel + 5'd1;
            n_r      <= n_r + 5'd1;
            took_r   <= 1'b1;
          end else begin
            keep_r <= keep_r + QCW'(1);
          end
          idx_r <= idx_r + QCW'(1);
        end
        S_PASS: begin
          cnt_r[pos_r] <= keep_r;
          if (!pass_r && !took_r && keep_r != '0) begin
            up_r   <= !up_r;
            pass_r <= 1'b1;
            idx_r  <= '0;
            keep_r <= '0;
            took_r <= 1'b0;
          end
        end
        S_MOVE: begin
          moved_r <= 1'b1;
          if (!(up_r ? want_up : want_dn)) begin
            if (n_r != 5'd0) begin
              if (up_r ? want_dn : want_up) begin
                up_r <= !up_r;
              end else if (pos_r != '0) begin
                pos_r <= pos_r - 3'd1;
              end
            end else if (above) begin
              up_r  <= 1'b1;
              pos_r <= pos_r + 3'd1;
            end else if (below) begin
              up_r  <= 1'b0;
              pos_r <= pos_r - 3'd1;
            end
          end else if (up_r && {1'b0, pos_r} < 4'(NUM_FLOORS - 1)) begin
            pos_r <= pos_r + 3'd1;
          end else if (!up_r && pos_r != '0) begin
            pos_r <= pos_r - 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: design/elevator_dispatch_controller.sv
// Top level of the elevator dispatch controller: config registers, front,
// back and a two-entry result queue. Depends on edc_pkg, edc_front, edc_back and the macros header.
//
// Each transaction is carried out one at a time by the back-end sequencer.
// An add request, or a tick with an empty car and no waiting passengers,
// goes from idle straight to the done state. Any other tick reads and
// evaluates each passenger in the current floor's queue, with a read and an
// evaluation on the waiting-destination RAM for each, then passes, moves and
// finishes; when the direction flips for a second boarding pass, it scans again.
// Input and result queues of two entries each let both sides stall freely.
`timescale 1ns / 1ps

module elevator_dispatch_controller
  import edc_pkg::*;
#(
  parameter int NUM_FLOORS  = 6,
  parameter int QUEUE_DEPTH = 8,
  parameter int CAB_LIMIT   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

`include "elevator_dispatch_controller_macros.svh"

  cfg_t      cfg_r;
  logic      wk_valid, wk_pop, res_valid, res_ready;
  work_t     wk;
  out_item_t res;
  logic [FLW-1:0] to_q_r [2];
  logic      to_wp_r, to_rp_r;

  out_item_t oq_r [2];
  logic      owp_r, orp_r;
  logic [1:0] out_cnt_r, out_cnt_nxt;
  logic      res_push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{max_load: MAX_LOAD_RST, rider_weight: RIDER_WEIGHT_RST,
                 idle_limit: IDLE_LIMIT_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_LOAD:     cfg_r.max_load     <= cfg_wdata;
        CFG_RIDER_WEIGHT: cfg_r.rider_weight <= cfg_wdata[7:0];
        CFG_IDLE_LIMIT:   cfg_r.idle_limit   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  edc_front #(.NUM_FLOORS(NUM_FLOORS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .wk_valid (wk_valid),
    .wk       (wk),
    .wk_pop   (wk_pop)
  );

  // destination floor travels beside the front queue, in pointers that move with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      to_wp_r <= 1'b0;
      to_rp_r <= 1'b0;
    end else begin
      if (in_push && !in_full) to_wp_r <= !to_wp_r;
      if (wk_pop && wk_valid)  to_rp_r <= !to_rp_r;
    end
    if (in_push && !in_full) to_q_r[to_wp_r] <= in_data.to_floor;
  end

  edc_back #(
    .NUM_FLOORS  (NUM_FLOORS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CAB_LIMIT   (CAB_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .wk_valid  (wk_valid),
    .wk        (wk),
    .wk_to     (to_q_r[to_rp_r]),
    .wk_pop    (wk_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready   = (out_cnt_r != 2'd2);
  assign res_push    = res_valid && res_ready;
  assign out_empty   = (out_cnt_r == 2'd0);
  assign pop         = out_pop && !out_empty;
  assign out_data    = oq_r[orp_r];
  assign out_cnt_nxt = out_cnt_r + 2'(res_push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r     <= 1'b0;
      orp_r     <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      if (res_push) owp_r <= !owp_r;
      if (pop)      orp_r <= !orp_r;
      out_cnt_r <= out_cnt_nxt;
    end
    if (res_push) oq_r[owp_r] <= res;
  end

  `EDC_CHECK(a_out_cnt_range, 1'b1, out_cnt_r != 2'd3, "result queue overflow")
  `EDC_CHECK(a_out_sane, !out_empty,
    (out_data.rider_count <= 5'(CAB_LIMIT)) && ({1'b0, out_data.car_floor} < 4'(NUM_FLOORS)),
    "result holds impossible rider count or floor")
  `EDC_CHECK_NEXT(a_pop_drains, pop && !res_push,
    out_cnt_r == $past(out_cnt_r) - 2'd1, "popped result not removed")

endmodule
